// ----- rtl/dlefr_pkg.sv -----
// ----------------------------------------------------------------------------
// dlefr_pkg
// shared types, symbols and sizes of the stx/etx/dle frame receiver
// ----------------------------------------------------------------------------
package dlefr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);

  // fixed field widths of the channels
  localparam int FUNC_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int RIDX_W      = 6;
  localparam int FLEN_W      = 7;

  // func codes
  localparam logic [FUNC_W-1:0] FUNC_LINE_BYTE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REARM     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ      = 2'd2;

  // line symbols
  localparam logic [BYTE_W-1:0] SYM_STX = 8'h02;
  localparam logic [BYTE_W-1:0] SYM_ETX = 8'h03;
  localparam logic [BYTE_W-1:0] SYM_DLE = 8'h10;

  // classified command handed from front to back
  typedef enum logic [2:0] {
    CMD_BYTE_STX,
    CMD_BYTE_ETX,
    CMD_BYTE_DLE,
    CMD_BYTE_OTHER,
    CMD_REARM,
    CMD_READ,
    CMD_NOP
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] data;
    logic [RIDX_W-1:0] index;
  } q_entry_t;

  // queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

// ----- rtl/dlefr_ifs.sv -----
// ----------------------------------------------------------------------------
// dlefr channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface dlefr_in_if;
  logic                              valid;
  logic                              ready;
  logic [dlefr_pkg::FUNC_W-1:0]      func;
  logic [dlefr_pkg::BYTE_W-1:0]      rx_byte;
  logic [dlefr_pkg::RIDX_W-1:0]      read_index;

  modport source (output valid, output func, output rx_byte, output read_index,
                  input ready);
  modport sink   (input valid, input func, input rx_byte, input read_index,
                  output ready);
endinterface

interface dlefr_out_if;
  logic                              valid;
  logic                              ready;
  logic                              frame_ready;
  logic [dlefr_pkg::FLEN_W-1:0]      frame_length;
  logic                              checksum_ok;
  logic [dlefr_pkg::BYTE_W-1:0]      read_data;

  modport source (output valid, output frame_ready, output frame_length,
                  output checksum_ok, output read_data, input ready);
  modport sink   (input valid, input frame_ready, input frame_length,
                  input checksum_ok, input read_data, output ready);
endinterface

// ----- rtl/dle_stuffed_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// dle_stuffed_frame_receiver_unit
// stx/etx/dle byte-stuffed frame receiver with payload store and sum check
// ----------------------------------------------------------------------------
//  channel  dir  payload                                            handshake
//  in_ch    in   func, rx_byte, read_index                          valid/ready
//  out_ch   out  frame_ready, frame_length, checksum_ok, read_data  valid/ready
//
//  one transaction per cycle sustained while out_ch is ready; each result passes
//  a queue slot, then the state update plus store read, before it leaves.
//  the store read port and the frame state update share the same execute cycle.
//  rst_n is synchronous; the payload store is not cleared.
//  a stalled output holds the result; input keeps flowing until the 2-entry
//  queue fills.
// ----------------------------------------------------------------------------
module dle_stuffed_frame_receiver_unit (
  input  logic       clk,
  input  logic       rst_n,
  dlefr_in_if.sink   in_ch,
  dlefr_out_if.source out_ch
);

  dlefr_pkg::q_entry_t q_entry;
  logic                q_valid;
  logic                q_ready;

  dlefr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_entry (q_entry),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  dlefr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_entry (q_entry),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule

// ----- rtl/dlefr_front.sv -----
// ----------------------------------------------------------------------------
// dlefr_front
// accepts input transactions, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module dlefr_front (
  input  logic                clk,
  input  logic                rst_n,
  dlefr_in_if.sink            in_ch,
  output dlefr_pkg::q_entry_t q_entry,
  output logic                q_valid,
  input  logic                q_ready
);

  dlefr_pkg::q_entry_t               slot_r [dlefr_pkg::QDEPTH];
  logic [dlefr_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [dlefr_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [dlefr_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  dlefr_pkg::q_entry_t               cls;
  logic                              push, pop;

  // symbol class only; escape resolution is done in the back end
  always_comb begin
    cls.data  = in_ch.rx_byte;
    cls.index = in_ch.read_index;
    case (in_ch.func)
      dlefr_pkg::FUNC_LINE_BYTE: begin
        case (in_ch.rx_byte)
          dlefr_pkg::SYM_STX: cls.cmd = dlefr_pkg::CMD_BYTE_STX;
          dlefr_pkg::SYM_ETX: cls.cmd = dlefr_pkg::CMD_BYTE_ETX;
          dlefr_pkg::SYM_DLE: cls.cmd = dlefr_pkg::CMD_BYTE_DLE;
          default:            cls.cmd = dlefr_pkg::CMD_BYTE_OTHER;
        endcase
      end
      dlefr_pkg::FUNC_REARM: cls.cmd = dlefr_pkg::CMD_REARM;
      dlefr_pkg::FUNC_READ:  cls.cmd = dlefr_pkg::CMD_READ;
      default:               cls.cmd = dlefr_pkg::CMD_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != dlefr_pkg::QCNT_W'(dlefr_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_valid && q_ready;
  assign q_entry     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dlefr_pkg::QCNT_W'(dlefr_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count lost a push");

  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_ready) |=> (q_valid && $stable(q_entry)))
    else $error("queue head changed while waiting");

endmodule

// ----- rtl/dlefr_back.sv -----
// ----------------------------------------------------------------------------
// dlefr_back
// frame state machine, payload store and registered result stage
// ----------------------------------------------------------------------------
module dlefr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dlefr_pkg::q_entry_t q_entry,
  input  logic                q_valid,
  output logic                q_ready,
  dlefr_out_if.source         out_ch
);

  logic [dlefr_pkg::BYTE_W-1:0] mem [dlefr_pkg::MAX_PAYLOAD];

  logic                          done_r, done_nxt;
  logic                          in_frame_r, in_frame_nxt;
  logic                          esc_r, esc_nxt;
  logic [dlefr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [dlefr_pkg::BYTE_W-1:0]  sum_r, sum_nxt;
  logic [dlefr_pkg::BYTE_W-1:0]  last_r, last_nxt;
  logic [dlefr_pkg::CNT_W-1:0]   held_len_r, held_len_nxt;
  logic                          held_ok_r, held_ok_nxt;

  logic                          mem_we;
  logic                          exec;
  logic                          is_read;
  logic                          out_valid_r, out_valid_nxt;
  logic                          res_read_r;
  logic [dlefr_pkg::BYTE_W-1:0]  rd_q_r;
  logic                          is_line, etx_hit;

  assign q_ready = !out_valid_r || out_ch.ready;
  assign exec    = q_valid && q_ready;
  assign is_read = (q_entry.cmd == dlefr_pkg::CMD_READ) &&
                   (32'(q_entry.index) < dlefr_pkg::MAX_PAYLOAD);

  always_comb begin
    is_line = q_entry.cmd inside {dlefr_pkg::CMD_BYTE_STX, dlefr_pkg::CMD_BYTE_ETX,
                                  dlefr_pkg::CMD_BYTE_DLE, dlefr_pkg::CMD_BYTE_OTHER};
  end

  always_comb begin
    done_nxt     = done_r;
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    last_nxt     = last_r;
    held_len_nxt = held_len_r;
    held_ok_nxt  = held_ok_r;
    mem_we       = 1'b0;
    etx_hit      = 1'b0;
    if (is_line && !done_r) begin
      if (q_entry.cmd == dlefr_pkg::CMD_BYTE_STX && !esc_r) begin
        in_frame_nxt = 1'b1;
        cnt_nxt      = '0;
        sum_nxt      = '0;
      end else if (q_entry.cmd == dlefr_pkg::CMD_BYTE_ETX && !esc_r && in_frame_r) begin
        etx_hit      = 1'b1;
        in_frame_nxt = 1'b0;
        done_nxt     = 1'b1;
        held_len_nxt = cnt_r;
        // last_r always mirrors the newest stored byte
        held_ok_nxt  = (cnt_r != '0) && (sum_r == last_r);
        cnt_nxt      = '0;
      end else if (q_entry.cmd == dlefr_pkg::CMD_BYTE_DLE && !esc_r) begin
        esc_nxt = 1'b1;
      end else if (in_frame_r) begin
        esc_nxt = 1'b0;
        if (cnt_r < dlefr_pkg::CNT_W'(dlefr_pkg::MAX_PAYLOAD)) begin
          if (cnt_r != '0) begin
            sum_nxt = sum_r + last_r;
          end
          mem_we   = 1'b1;
          last_nxt = q_entry.data;
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          // overlong frame, drop it silently
          in_frame_nxt = 1'b0;
          cnt_nxt      = '0;
        end
      end else begin
        esc_nxt = 1'b0;
      end
    end else if (q_entry.cmd == dlefr_pkg::CMD_REARM) begin
      done_nxt = 1'b0;
      cnt_nxt  = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 1'b0;
      in_frame_r  <= 1'b0;
      esc_r       <= 1'b0;
      cnt_r       <= '0;
      sum_r       <= '0;
      last_r      <= '0;
      held_len_r  <= '0;
      held_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        done_r     <= done_nxt;
        in_frame_r <= in_frame_nxt;
        esc_r      <= esc_nxt;
        cnt_r      <= cnt_nxt;
        sum_r      <= sum_nxt;
        last_r     <= last_nxt;
        held_len_r <= held_len_nxt;
        held_ok_r  <= held_ok_nxt;
      end
    end
  end

  // payload store, registered read
  always_ff @(posedge clk) begin
    if (exec && mem_we) begin
      mem[cnt_r[dlefr_pkg::IDX_W-1:0]] <= q_entry.data;
    end
    if (exec) begin
      rd_q_r     <= mem[dlefr_pkg::IDX_W'(q_entry.index)];
      res_read_r <= is_read;
    end
  end

  // frame state after the last executed item is the result
  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_ready  = done_r;
  assign out_ch.frame_length = dlefr_pkg::FLEN_W'(held_len_r);
  assign out_ch.checksum_ok  = held_ok_r;
  assign out_ch.read_data    = res_read_r ? rd_q_r : '0;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dlefr_pkg::CNT_W'(dlefr_pkg::MAX_PAYLOAD))
    else $error("byte count beyond capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !in_frame_r)
    else $error("frame held while still receiving");

  a_etx_done: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && etx_hit) |=> (done_r && cnt_r == '0))
    else $error("etx did not complete the frame");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !exec |=> ($stable(done_r) && $stable(cnt_r) && $stable(held_len_r)))
    else $error("frame state moved without an executed item");

endmodule
